// ===== sv/lhfs_pkg.sv =====
// Package for the five-stage link handshake: payload structs, stage codes,
// character constants and the single-stage guard check.
// No dependencies; used by every other file of the block.
package lhfs_pkg;

  // Number of words exchanged with the partner
  localparam int unsigned NumWords = 8;
  localparam int unsigned WordW    = 16;
  // Unready-frame counter width; the count saturates at all ones
  localparam int unsigned MissW    = 8;
  // Register file: two 32-bit registers at byte offsets 0 and 4
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  // Register indexes (paddr[2])
  localparam logic REG_LINK_EN = 1'b0;
  localparam logic REG_CANCEL  = 1'b1;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  // Both transfer-ready bits set
  localparam logic [1:0] RDY_BOTH = 2'b11;

  // Result status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_OK   = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  // Handshake characters
  localparam logic [WordW-1:0] CH_LC_E = 16'h0065; // 'e'
  localparam logic [WordW-1:0] CH_LC_X = 16'h0078; // 'x'
  localparam logic [WordW-1:0] CH_UC_T = 16'h0054; // 'T'
  localparam logic [WordW-1:0] CH_UC_U = 16'h0055; // 'U'
  localparam logic [WordW-1:0] CH_LC_R = 16'h0072; // 'r'
  localparam logic [WordW-1:0] CH_LC_N = 16'h006E; // 'n'
  localparam logic [WordW-1:0] CH_UC_E = 16'h0045; // 'E'
  localparam logic [WordW-1:0] CH_UC_X = 16'h0058; // 'X'
  localparam logic [WordW-1:0] CH_UC_C = 16'h0043; // 'C'
  localparam logic [WordW-1:0] CH_LC_T = 16'h0074; // 't'
  localparam logic [WordW-1:0] CH_LC_U = 16'h0075; // 'u'
  localparam logic [WordW-1:0] CH_UC_R = 16'h0052; // 'R'
  localparam logic [WordW-1:0] CH_UC_N = 16'h004E; // 'N'

  // Handshake stage, one-hot
  typedef enum logic [5:0] {
    STG_IDLE = 6'b000001,
    STG_1    = 6'b000010,
    STG_2    = 6'b000100,
    STG_3    = 6'b001000,
    STG_4    = 6'b010000,
    STG_5    = 6'b100000
  } stage_e;

  // Number of stage evaluations one ready frame can chain through
  localparam int unsigned NumStages = 5;

  // Outcome of one stage evaluation
  typedef enum logic [1:0] {
    STEP_WAIT = 2'd0,
    STEP_ADV  = 2'd1,
    STEP_OK   = 2'd2,
    STEP_FAIL = 2'd3
  } step_code_e;

  typedef logic [NumWords-1:0][WordW-1:0] word_arr_t;

  typedef struct packed {
    step_code_e code;
    word_arr_t  words;
  } step_t;

  // Input transaction
  typedef struct packed {
    logic             action;
    logic [1:0]       ready_bits;
    logic [WordW-1:0] peer_word0;
    logic [WordW-1:0] peer_word1;
    logic [WordW-1:0] peer_word2;
    logic [WordW-1:0] peer_word3;
    logic [WordW-1:0] peer_word4;
    logic [WordW-1:0] peer_word5;
    logic [WordW-1:0] peer_word6;
    logic [WordW-1:0] peer_word7;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]       status;
    logic [WordW-1:0] send_word0;
    logic [WordW-1:0] send_word1;
    logic [WordW-1:0] send_word2;
    logic [WordW-1:0] send_word3;
    logic [WordW-1:0] send_word4;
    logic [WordW-1:0] send_word5;
    logic [WordW-1:0] send_word6;
    logic [WordW-1:0] send_word7;
  } out_t;

  // Configuration bits handed from the register file to the datapath
  typedef struct packed {
    logic link_enable;
    logic cancel_flag;
  } cfg_t;

  // Handshake state
  typedef struct packed {
    stage_e           stage;
    logic [MissW-1:0] miss;
    word_arr_t        words;
  } state_t;

  // Guard check of one stage against the current peer sample
  function automatic step_t eval_stage(stage_e stg, word_arr_t lw, word_arr_t pw);
    step_t res;
    res.code  = STEP_WAIT;
    res.words = lw;
    unique case (stg)
      STG_1: begin
        if (lw[3:2] != pw[3:2]) begin
          res.code = STEP_FAIL;
        end else if (lw[1:0] == pw[1:0] && lw[5:4] == pw[5:4]) begin
          res.words[6] = CH_LC_R;
          res.words[7] = CH_LC_N;
          res.code     = STEP_ADV;
        end
      end
      STG_2: begin
        if (lw[5:4] != pw[5:4]) begin
          res.code = STEP_FAIL;
        end else if (lw[7:6] == pw[7:6]) begin
          res.words[0] = CH_UC_E;
          res.words[1] = CH_UC_X;
          res.words[2] = CH_UC_E;
          res.words[3] = CH_UC_C;
          res.code     = STEP_ADV;
        end
      end
      STG_3: begin
        if (lw[7:6] != pw[7:6]) begin
          res.code = STEP_FAIL;
        end else if (lw[3:0] == pw[3:0]) begin
          res.words[4] = CH_LC_T;
          res.words[5] = CH_LC_U;
          res.code     = STEP_ADV;
        end
      end
      STG_4: begin
        if (lw[3:0] != pw[3:0]) begin
          res.code = STEP_FAIL;
        end else if (lw[5:4] == pw[5:4]) begin
          res.words[6] = CH_UC_R;
          res.words[7] = CH_UC_N;
          res.code     = STEP_ADV;
        end
      end
      STG_5: begin
        // peer has moved off 'r','n'
        if (pw[6] != CH_LC_R || pw[7] != CH_LC_N) begin
          res.code = STEP_OK;
        end
      end
      default: begin
        res.code = STEP_WAIT;
      end
    endcase
    return res;
  endfunction

endpackage

// ===== sv/lhfs_apb_regs.sv =====
// APB register file for the link handshake: link_enable and cancel_flag.
// Depends on lhfs_pkg for widths, register indexes and cfg_t.
module lhfs_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lhfs_pkg::AddrW-1:0]   paddr,
  input  logic [lhfs_pkg::DataW-1:0]   pwdata,
  output logic [lhfs_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output lhfs_pkg::cfg_t               cfg_o
);

  lhfs_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[2];

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        lhfs_pkg::REG_LINK_EN: cfg_d.link_enable = pwdata[0];
        lhfs_pkg::REG_CANCEL:  cfg_d.cancel_flag = pwdata[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link_enable <= 1'b1;
      cfg_q.cancel_flag <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lhfs_pkg::REG_LINK_EN: prdata[0] = cfg_q.link_enable;
      lhfs_pkg::REG_CANCEL:  prdata[0] = cfg_q.cancel_flag;
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/lhfs_step.sv =====
// Next-state and result logic for one transaction of the link handshake:
// start handling, timeout counting and the chained stage checks.
// Depends on lhfs_pkg for types, codes and eval_stage.
module lhfs_step #(
  parameter int unsigned TIMEOUT_LIMIT = 24
) (
  input  lhfs_pkg::in_t    item_i,
  input  lhfs_pkg::cfg_t   cfg_i,
  input  lhfs_pkg::state_t state_i,
  output lhfs_pkg::state_t state_o,
  output lhfs_pkg::out_t   result_o
);

  localparam logic [lhfs_pkg::MissW-1:0] Limit = lhfs_pkg::MissW'(TIMEOUT_LIMIT);

  lhfs_pkg::word_arr_t          peer;
  logic [lhfs_pkg::MissW-1:0]   miss_inc;
  logic [1:0]                   status;

  // Peer sample as an array
  always_comb begin
    peer[0] = item_i.peer_word0;
    peer[1] = item_i.peer_word1;
    peer[2] = item_i.peer_word2;
    peer[3] = item_i.peer_word3;
    peer[4] = item_i.peer_word4;
    peer[5] = item_i.peer_word5;
    peer[6] = item_i.peer_word6;
    peer[7] = item_i.peer_word7;
  end

  // Saturating unready-frame count
  assign miss_inc = (state_i.miss != '1) ? lhfs_pkg::MissW'(state_i.miss + 1'b1)
                                          : state_i.miss;

  // Transaction decode and stage chain
  always_comb begin
    lhfs_pkg::stage_e    cur;
    lhfs_pkg::word_arr_t words;
    lhfs_pkg::step_t     step;
    logic                done;
    state_o = state_i;
    status  = lhfs_pkg::ST_IDLE;
    cur     = state_i.stage;
    words   = state_i.words;
    step    = '0;
    done    = 1'b0;
    if (item_i.action == lhfs_pkg::ACT_START) begin
      state_o.miss = '0;
      if (!cfg_i.link_enable) begin
        state_o.stage = lhfs_pkg::STG_IDLE;
        status        = lhfs_pkg::ST_OK;
      end else if (cfg_i.cancel_flag) begin
        state_o.stage = lhfs_pkg::STG_IDLE;
        status        = lhfs_pkg::ST_FAIL;
      end else begin
        state_o.words[0] = lhfs_pkg::CH_LC_E;
        state_o.words[1] = lhfs_pkg::CH_LC_X;
        state_o.words[4] = lhfs_pkg::CH_UC_T;
        state_o.words[5] = lhfs_pkg::CH_UC_U;
        state_o.stage    = lhfs_pkg::STG_1;
        status           = lhfs_pkg::ST_WAIT;
      end
    end else if (state_i.stage != lhfs_pkg::STG_IDLE) begin
      if (item_i.ready_bits != lhfs_pkg::RDY_BOTH) begin
        // unready frame: count toward timeout
        if (miss_inc > Limit) begin
          state_o.stage = lhfs_pkg::STG_IDLE;
          state_o.miss  = '0;
          status        = lhfs_pkg::ST_FAIL;
        end else begin
          state_o.miss  = miss_inc;
          status        = lhfs_pkg::ST_WAIT;
        end
      end else begin
        // ready frame: stages advance in a chain on the same sample
        state_o.miss = '0;
        status       = lhfs_pkg::ST_WAIT;
        for (int k = 0; k < lhfs_pkg::NumStages; k++) begin
          if (!done) begin
            step  = lhfs_pkg::eval_stage(cur, words, peer);
            words = step.words;
            unique case (step.code)
              lhfs_pkg::STEP_ADV: begin
                cur = lhfs_pkg::stage_e'(cur << 1);
              end
              lhfs_pkg::STEP_OK: begin
                cur    = lhfs_pkg::STG_IDLE;
                status = lhfs_pkg::ST_OK;
                done   = 1'b1;
              end
              lhfs_pkg::STEP_FAIL: begin
                cur    = lhfs_pkg::STG_IDLE;
                status = lhfs_pkg::ST_FAIL;
                done   = 1'b1;
              end
              default: begin
                done = 1'b1;
              end
            endcase
          end
        end
        state_o.stage = cur;
        state_o.words = words;
      end
    end
  end

  // Result assembly from the updated words
  always_comb begin
    result_o.status     = status;
    result_o.send_word0 = state_o.words[0];
    result_o.send_word1 = state_o.words[1];
    result_o.send_word2 = state_o.words[2];
    result_o.send_word3 = state_o.words[3];
    result_o.send_word4 = state_o.words[4];
    result_o.send_word5 = state_o.words[5];
    result_o.send_word6 = state_o.words[6];
    result_o.send_word7 = state_o.words[7];
  end

endmodule

// ===== sv/link_handshake_five_stage.sv =====
// Five-stage link handshake: top level with input register, step logic,
// result register and APB register file. Depends on lhfs_pkg, lhfs_step
// and lhfs_apb_regs.
//
// One transaction is accepted per clock cycle while no result is stalled, and
// each one yields exactly one result. An accepted transaction sits in the
// input register; once the result register is empty or being taken, the
// step logic (start decode, timeout count, then up to five chained stage
// checks against the same peer sample) updates the handshake state and loads
// the result register in the same edge, so the following transaction sees
// the updated state. The input register frees as soon as the result register
// is empty or being taken, so a new transaction can enter while a result
// still waits. Registers link_enable (offset 0) and cancel_flag (offset 4)
// should be written only while no transaction is in flight.
module link_handshake_five_stage #(
  parameter int unsigned TIMEOUT_LIMIT = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lhfs_pkg::in_t                in_data_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lhfs_pkg::out_t               out_data_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lhfs_pkg::AddrW-1:0]   paddr,
  input  logic [lhfs_pkg::DataW-1:0]   pwdata,
  output logic [lhfs_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  lhfs_pkg::cfg_t   cfg;
  lhfs_pkg::state_t state_q, state_d;
  lhfs_pkg::in_t    inq_data_q;
  logic             inq_valid_q;
  lhfs_pkg::out_t   out_data_q, result;
  logic             out_valid_q;
  logic             adv;
  logic             fire;

  lhfs_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lhfs_step #(
    .TIMEOUT_LIMIT (TIMEOUT_LIMIT)
  ) u_step (
    .item_i   (inq_data_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Handshake control
  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = inq_valid_q && adv;
  assign in_ready_o = !inq_valid_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      inq_valid_q <= 1'b1;
    end else if (fire) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_data_q <= in_data_i;
    end
  end

  // Handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage <= lhfs_pkg::STG_IDLE;
      state_q.miss  <= '0;
      state_q.words <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/lhfs_checker.sv =====
// Port-level checks for link_handshake_five_stage, attached with bind.
// Depends on lhfs_pkg for the payload types.
module lhfs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input lhfs_pkg::out_t               out_data_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Input backpressure only when a result is stalled
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // A fresh result follows an accepted transaction through the input and result registers
  a_rise_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a matching transaction");

endmodule

bind link_handshake_five_stage lhfs_checker u_lhfs_checker (.*);

// ===== test/lhfs_link_checker.sv =====
// Scoreboard for the five-stage link handshake: follows the APB register writes,
// predicts the one result of every accepted transaction and checks results in order.
// Depends on lhfs_pkg.
module lhfs_link_checker
  import lhfs_pkg::*;
#(
  parameter int unsigned TimeoutLimit = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_t              in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_t             out_data_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Keeps the log readable when the block is badly broken
  localparam int MaxReports = 200;

  // Shadow of the handshake state and register file
  stage_e           hs_stage;
  logic [MissW-1:0] miss_run;
  word_arr_t        link_words;
  logic             cfg_link_en;
  logic             cfg_cancel;

  out_t expected_link_out[$];
  out_t predicted;

  // Local words lo..hi against the same partner words
  function automatic logic words_match(word_arr_t peer, int lo, int hi);
    int i;
    for (i = lo; i <= hi; i++) begin
      if (link_words[i] != peer[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // One transaction through the handshake: updates the shadow state
  task automatic step_link_handshake(input in_t t, output out_t res);
    word_arr_t  peer;
    logic [1:0] status;
    step_code_e step;
    peer = {t.peer_word7, t.peer_word6, t.peer_word5, t.peer_word4,
            t.peer_word3, t.peer_word2, t.peer_word1, t.peer_word0};
    status = ST_IDLE;
    if (t.action == ACT_START) begin
      miss_run = '0;
      if (!cfg_link_en) begin
        hs_stage = STG_IDLE;
        status   = ST_OK;
      end else if (cfg_cancel) begin
        hs_stage = STG_IDLE;
        status   = ST_FAIL;
      end else begin
        link_words[0] = CH_LC_E;
        link_words[1] = CH_LC_X;
        link_words[4] = CH_UC_T;
        link_words[5] = CH_UC_U;
        hs_stage      = STG_1;
        status        = ST_WAIT;
      end
    end else if (hs_stage == STG_IDLE) begin
      // frame with no handshake running: ignored
      status = ST_IDLE;
    end else if (t.ready_bits != RDY_BOTH) begin
      if (miss_run != '1) miss_run = miss_run + 1'b1;
      if (miss_run > TimeoutLimit) begin
        hs_stage = STG_IDLE;
        miss_run = '0;
        status   = ST_FAIL;
      end else begin
        status = ST_WAIT;
      end
    end else begin
      miss_run = '0;
      status   = ST_WAIT;
      // stages chain on the same sample as long as each one advances
      step = STEP_ADV;
      while (step == STEP_ADV) begin
        step = STEP_WAIT;
        case (hs_stage)
          STG_1: begin
            if (!words_match(peer, 2, 3)) begin
              step = STEP_FAIL;
            end else if (words_match(peer, 0, 1) && words_match(peer, 4, 5)) begin
              link_words[6] = CH_LC_R;
              link_words[7] = CH_LC_N;
              hs_stage      = STG_2;
              step          = STEP_ADV;
            end
          end
          STG_2: begin
            if (!words_match(peer, 4, 5)) begin
              step = STEP_FAIL;
            end else if (words_match(peer, 6, 7)) begin
              link_words[0] = CH_UC_E;
              link_words[1] = CH_UC_X;
              link_words[2] = CH_UC_E;
              link_words[3] = CH_UC_C;
              hs_stage      = STG_3;
              step          = STEP_ADV;
            end
          end
          STG_3: begin
            if (!words_match(peer, 6, 7)) begin
              step = STEP_FAIL;
            end else if (words_match(peer, 0, 3)) begin
              link_words[4] = CH_LC_T;
              link_words[5] = CH_LC_U;
              hs_stage      = STG_4;
              step          = STEP_ADV;
            end
          end
          STG_4: begin
            if (!words_match(peer, 0, 3)) begin
              step = STEP_FAIL;
            end else if (words_match(peer, 4, 5)) begin
              link_words[6] = CH_UC_R;
              link_words[7] = CH_UC_N;
              hs_stage      = STG_5;
              step          = STEP_ADV;
            end
          end
          STG_5: begin
            // done once the partner has left 'r','n'
            if (peer[6] != CH_LC_R || peer[7] != CH_LC_N) step = STEP_OK;
          end
          default: begin
            step = STEP_WAIT;
          end
        endcase
      end
      if (step == STEP_OK) begin
        hs_stage = STG_IDLE;
        status   = ST_OK;
      end else if (step == STEP_FAIL) begin
        hs_stage = STG_IDLE;
        status   = ST_FAIL;
      end
    end
    res.status     = status;
    res.send_word0 = link_words[0];
    res.send_word1 = link_words[1];
    res.send_word2 = link_words[2];
    res.send_word3 = link_words[3];
    res.send_word4 = link_words[4];
    res.send_word5 = link_words[5];
    res.send_word6 = link_words[6];
    res.send_word7 = link_words[7];
  endtask

  task automatic check_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
    if (want !== got) begin
      if (fail_count_o < MaxReports) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
      fail_count_o++;
    end
  endtask

  // Result transaction against the oldest prediction
  task automatic compare_link_out(out_t got);
    out_t want;
    if (expected_link_out.size() == 0) begin
      if (fail_count_o < MaxReports) begin
        $display("%0t: result with nothing expected, got status %h", $time, got.status);
      end
      fail_count_o++;
      return;
    end
    want = expected_link_out.pop_front();
    check_field("status", 16'(want.status), 16'(got.status));
    check_field("send_word0", want.send_word0, got.send_word0);
    check_field("send_word1", want.send_word1, got.send_word1);
    check_field("send_word2", want.send_word2, got.send_word2);
    check_field("send_word3", want.send_word3, got.send_word3);
    check_field("send_word4", want.send_word4, got.send_word4);
    check_field("send_word5", want.send_word5, got.send_word5);
    check_field("send_word6", want.send_word6, got.send_word6);
    check_field("send_word7", want.send_word7, got.send_word7);
  endtask

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_stage     = STG_IDLE;
      miss_run     = '0;
      link_words   = '0;
      cfg_link_en  = 1'b1;
      cfg_cancel   = 1'b0;
      expected_link_out.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // results first, so a prediction pushed this edge never pairs with them
      if (out_valid_i && out_ready_i) compare_link_out(out_data_i);
      if (in_valid_i && in_ready_i) begin
        step_link_handshake(in_data_i, predicted);
        expected_link_out.push_back(predicted);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_CANCEL) begin
          cfg_cancel = pwdata_i[0];
        end else begin
          cfg_link_en = pwdata_i[0];
        end
      end
      pending_o = expected_link_out.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the link handshake regression: clock, reset, stimulus, register
// writes and verdict. Depends on lhfs_pkg, link_handshake_five_stage and
// lhfs_link_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lhfs_pkg::*;

  localparam int unsigned TimeoutLimit = 24;
  localparam int RandomItems   = 600;
  localparam int StallCycles   = 60;
  localparam int WatchdogLimit = 1000;
  localparam int SettleCycles  = 4;
  // Register settings per random phase: {link_enable, cancel_flag}
  localparam logic [1:0] PhaseCfg [6] = '{2'b10, 2'b01, 2'b10, 2'b11, 2'b10, 2'b00};

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             psel      = 1'b0;
  logic             penable   = 1'b0;
  logic             pwrite    = 1'b0;
  logic [AddrW-1:0] paddr     = '0;
  logic [DataW-1:0] pwdata    = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  int        fail_count;
  int        pending;
  int        items_sent   = 0;
  int        stuck_cycles = 0;
  bit        steady       = 1'b0;
  // toggled by the stimulus to ask for a long hold-off on results
  bit        stall_req    = 1'b0;
  word_arr_t last_send_words = '0;

  always #5ns clk = ~clk;

  link_handshake_five_stage #(
    .TIMEOUT_LIMIT(TimeoutLimit)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  lhfs_link_checker #(
    .TimeoutLimit(TimeoutLimit)
  ) link_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Outgoing words as the partner sees them
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      last_send_words <= {out_data.send_word7, out_data.send_word6, out_data.send_word5,
                          out_data.send_word4, out_data.send_word3, out_data.send_word2,
                          out_data.send_word1, out_data.send_word0};
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchdogLimit) begin
      $display("link_handshake_five_stage regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin : result_sink
    int hold;
    bit stall_seen;
    hold       = 0;
    stall_seen = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        hold       = StallCycles;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 23);
      end
    end
  end

  function automatic word_arr_t words8(logic [WordW-1:0] w0, logic [WordW-1:0] w1,
                                       logic [WordW-1:0] w2, logic [WordW-1:0] w3,
                                       logic [WordW-1:0] w4, logic [WordW-1:0] w5,
                                       logic [WordW-1:0] w6, logic [WordW-1:0] w7);
    return {w7, w6, w5, w4, w3, w2, w1, w0};
  endfunction

  function automatic word_arr_t rand_words();
    word_arr_t w;
    int i;
    for (i = 0; i < NumWords; i++) begin
      case ($urandom_range(9))
        0:       w[i] = '0;
        1:       w[i] = '1;
        default: w[i] = 16'($urandom_range(65535));
      endcase
    end
    return w;
  endfunction

  function automatic in_t make_item(logic act, logic [1:0] rdy, word_arr_t w);
    in_t t;
    t.action     = act;
    t.ready_bits = rdy;
    t.peer_word0 = w[0];
    t.peer_word1 = w[1];
    t.peer_word2 = w[2];
    t.peer_word3 = w[3];
    t.peer_word4 = w[4];
    t.peer_word5 = w[5];
    t.peer_word6 = w[6];
    t.peer_word7 = w[7];
    return t;
  endfunction

  // Any transaction; start_pct percent are starts
  function automatic in_t noise_item(int start_pct);
    logic act;
    act = ($urandom_range(99) < start_pct) ? ACT_START : ACT_FRAME;
    return make_item(act, 2'($urandom_range(3)), rand_words());
  endfunction

  // Offer one transaction, with random idle cycles ahead of it
  task automatic push_link_item(in_t t);
    while (!steady && $urandom_range(99) < 23) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop offering and wait until every result is back
  task automatic drain_link();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic apb_write(logic idx, logic [DataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_link_cfg(logic en, logic cancel);
    drain_link();
    apb_write(REG_LINK_EN, DataW'(en));
    apb_write(REG_CANCEL, DataW'(cancel));
  endtask

  // A partner that mirrors the outgoing words stage by stage, with unready
  // runs, occasional damaged frames, restarts and timeouts mixed in
  task automatic run_handshake();
    word_arr_t mirror;
    word_arr_t peer;
    word_arr_t damaged;
    int        stg;
    int        misses;
    int        pick;
    int        n;
    int        wi;
    int        bi;
    push_link_item(make_item(ACT_START, 2'($urandom_range(3)), rand_words()));
    drain_link();
    mirror = last_send_words;
    for (stg = 1; stg <= NumStages; stg++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        misses = TimeoutLimit + 1;
      end else if (pick < 10) begin
        misses = TimeoutLimit;
      end else begin
        misses = $urandom_range(2);
      end
      for (n = 0; n < misses; n++) begin
        push_link_item(make_item(ACT_FRAME, 2'($urandom_range(2)), rand_words()));
      end
      if (misses > TimeoutLimit) return;
      if ($urandom_range(99) < 3) begin
        push_link_item(make_item(ACT_START, RDY_BOTH, rand_words()));
        return;
      end
      if (stg == NumStages) begin
        // partner still on 'r','n' first, now and then
        if ($urandom_range(99) < 30) begin
          peer    = rand_words();
          peer[6] = CH_LC_R;
          peer[7] = CH_LC_N;
          push_link_item(make_item(ACT_FRAME, RDY_BOTH, peer));
        end
        peer    = rand_words();
        peer[7] = CH_UC_N;
        if ($urandom_range(1) != 0) peer[6] = CH_UC_R;
        push_link_item(make_item(ACT_FRAME, RDY_BOTH, peer));
      end else begin
        peer = mirror;
        // stage four ignores words 6 and 7: leaving 'r','n' finishes at once
        if (stg == 4 && $urandom_range(99) < 25) begin
          peer[6] = 16'($urandom_range(65535));
          peer[7] = 16'($urandom_range(65535));
        end
        if ($urandom_range(99) < 8) begin
          damaged         = peer;
          wi              = $urandom_range(NumWords - 1);
          bi              = $urandom_range(WordW - 1);
          damaged[wi][bi] = ~damaged[wi][bi];
          push_link_item(make_item(ACT_FRAME, RDY_BOTH, damaged));
        end
        push_link_item(make_item(ACT_FRAME, RDY_BOTH, peer));
        case (stg)
          1: begin
            mirror[6] = CH_LC_R;
            mirror[7] = CH_LC_N;
          end
          2: begin
            mirror[0] = CH_UC_E;
            mirror[1] = CH_UC_X;
            mirror[2] = CH_UC_E;
            mirror[3] = CH_UC_C;
          end
          3: begin
            mirror[4] = CH_LC_T;
            mirror[5] = CH_LC_U;
          end
          default: begin
            mirror = mirror;
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    int         phase;
    int         phase_end;
    int         random_start;
    logic [1:0] cfg;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_link_cfg(1'b1, 1'b0);

    // Directed: idle frames, unready frames, the failure of stages one to four,
    // chained advances through to success, restart while waiting
    push_link_item(make_item(ACT_FRAME, RDY_BOTH, '1));
    push_link_item(make_item(ACT_FRAME, 2'b00, '0));
    push_link_item(make_item(ACT_START, 2'b00, '1));
    push_link_item(make_item(ACT_FRAME, 2'b01, '0));
    push_link_item(make_item(ACT_FRAME, 2'b10, '1));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_LC_E, CH_LC_X, '1, '0, CH_UC_T, CH_UC_U, '0, '0)));
    push_link_item(make_item(ACT_START, 2'b00, '0));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_LC_E, CH_LC_X, '0, '0, CH_UC_T, CH_UC_U, '0, '0)));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_LC_E, CH_LC_X, '0, '0, '1, CH_UC_U, CH_LC_R, CH_LC_N)));
    push_link_item(make_item(ACT_START, RDY_BOTH, '0));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_LC_E, CH_LC_X, '0, '0, CH_UC_T, CH_UC_U, CH_LC_R, CH_LC_N)));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_UC_E, CH_UC_X, CH_UC_E, CH_UC_C, CH_UC_T, CH_UC_U, '0, CH_LC_N)));
    push_link_item(make_item(ACT_START, RDY_BOTH, '1));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_LC_E, CH_LC_X, CH_UC_E, CH_UC_C, CH_UC_T, CH_UC_U, CH_LC_R, CH_LC_N)));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_UC_E, CH_UC_X, CH_UC_E, CH_UC_C, CH_UC_T, CH_UC_U, CH_LC_R, CH_LC_N)));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_UC_E, CH_UC_X, CH_UC_E, '0, CH_LC_T, CH_LC_U, CH_LC_R, CH_LC_N)));
    push_link_item(make_item(ACT_START, RDY_BOTH, '0));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_LC_E, CH_LC_X, CH_UC_E, CH_UC_C, CH_UC_T, CH_UC_U, CH_LC_R, CH_LC_N)));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8(CH_UC_E, CH_UC_X, CH_UC_E, CH_UC_C, CH_LC_T, CH_LC_U, CH_LC_R, CH_LC_N)));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH,
      words8('1, '1, '1, '1, '1, '1, CH_UC_R, CH_UC_N)));
    push_link_item(make_item(ACT_START, RDY_BOTH, '0));
    push_link_item(make_item(ACT_START, 2'b01, '1));
    // Starts under each register setting
    set_link_cfg(1'b0, 1'b0);
    push_link_item(make_item(ACT_START, RDY_BOTH, '0));
    set_link_cfg(1'b0, 1'b1);
    push_link_item(make_item(ACT_START, RDY_BOTH, '1));
    set_link_cfg(1'b1, 1'b1);
    push_link_item(make_item(ACT_START, RDY_BOTH, '0));
    push_link_item(make_item(ACT_FRAME, RDY_BOTH, '1));

    // Random phases under rotating register settings
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RandomItems) begin
      cfg = PhaseCfg[phase % 6];
      set_link_cfg(cfg[1], cfg[0]);
      steady = (phase == 2);
      if (cfg == 2'b10) begin
        phase_end = items_sent + 130;
        // long hold-off on results while transactions keep coming
        stall_req = ~stall_req;
        repeat (20) push_link_item(noise_item(30));
        while (items_sent < phase_end) begin
          if ($urandom_range(99) < 85) begin
            run_handshake();
          end else begin
            push_link_item(noise_item(30));
          end
        end
      end else begin
        repeat (25) push_link_item(noise_item(50));
      end
      phase++;
    end
    steady = 1'b0;
    drain_link();

    if (fail_count == 0 && pending == 0) begin
      $display("link_handshake_five_stage regression: pass");
    end else begin
      $display("link_handshake_five_stage regression: fail");
    end
    $finish;
  end

endmodule

// ===== link_handshake_five_stage.f =====
sv/lhfs_pkg.sv
sv/lhfs_apb_regs.sv
sv/lhfs_step.sv
sv/link_handshake_five_stage.sv
sv/lhfs_checker.sv
test/lhfs_link_checker.sv
test/testbench.sv
